[rtl/gwrc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Grid wavefront reachability check: shared types and constants
// Beat layouts of the request and response channels, cell kinds and the
// label encoding used by the distance flood.
// ----------------------------------------------------------------------------
package gwrc_pkg;

    localparam int LBL_W = 12;

    localparam logic [2:0] KIND_EMPTY = 3'd0;
    localparam logic [2:0] KIND_WALL  = 3'd1;
    localparam logic [2:0] KIND_START = 3'd2;
    localparam logic [2:0] KIND_EXIT  = 3'd3;
    localparam logic [2:0] KIND_KEY   = 3'd4;

    localparam logic       REQ_WRITE = 1'b0;
    localparam logic       REQ_TEST  = 1'b1;

    localparam logic [LBL_W-1:0] LBL_BASE   = 12'd100;
    localparam logic [LBL_W-1:0] LBL_MAX    = 12'd4095;
    localparam logic [LBL_W-1:0] COST_LAYER = 12'd6;
    localparam logic [LBL_W-1:0] COST_FLAT  = 12'd1;

    typedef struct packed {
        logic       req_type;
        logic [8:0] cell_index;
        logic [2:0] cell_kind;
    } req_t;

    typedef struct packed {
        logic        placement_ok;
        logic [11:0] difficulty;
    } rsp_t;

endpackage
`default_nettype wire

[rtl/gwrc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gwrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/grid_wavefront_reachability_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Grid wavefront reachability check
// Holds a cubic grid of cell kinds and tests whether walling one cell keeps
// the exit and all keys reachable from the start cells.
//
// The request channel (req_valid/req_ready/req) carries write beats and test
// beats. A write beat stores one cell kind and gives no response. A test
// beat gives one response beat (rsp_valid/rsp_ready/rsp). key_count is to be
// written through cfg_we/cfg_wdata only while the block is idle; the block
// itself does not enforce this. A test of an occupied cell goes from the
// check step straight to the final step. Otherwise the check step and a copy
// of the cell kinds into the label memory are followed by raster passes; a
// pass reads each cell's label and, for a labelled cell, each in-grid
// neighbor's label, since every label access goes through the single read
// port of the label memory. Only one request is worked on at a time;
// req_ready is high only while idle. A finished response waits in the output
// register while rsp_ready is low; write beats are still taken then, and a
// further test holds in its last step until that register is free. After
// reset the cell memory is swept to empty with req_ready low.
// ----------------------------------------------------------------------------
module grid_wavefront_reachability_check
    import gwrc_pkg::*;
#(
    parameter int GRID_SIDE = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_t       req,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_t            rsp,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata
);

    localparam int LAYER_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW          = $clog2(GRID_CELLS);
    localparam int CW          = $clog2(GRID_SIDE);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CHK   = 4'd2;
    localparam logic [3:0] ST_COPY  = 4'd3;
    localparam logic [3:0] ST_SRD   = 4'd4;
    localparam logic [3:0] ST_SOWN  = 4'd5;
    localparam logic [3:0] ST_NISS  = 4'd6;
    localparam logic [3:0] ST_NUSE  = 4'd7;
    localparam logic [3:0] ST_ADV   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic [AW-1:0]    cand_reg, cand_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [2:0]       nb_reg, nb_next;
    logic [LBL_W-1:0] own_reg, own_next;
    logic [LBL_W-1:0] last_reg, last_next;
    logic [4:0]       found_reg, found_next;
    logic             changed_reg, changed_next;
    logic [3:0]       key_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             cell_we;
    logic [AW-1:0]    cell_waddr, cell_raddr;
    logic [2:0]       cell_wdata, cell_rdata;
    logic             lbl_we;
    logic [AW-1:0]    lbl_waddr, lbl_raddr;
    logic [LBL_W-1:0] lbl_wdata, lbl_rdata;

    logic             in_grid;
    logic [AW-1:0]    req_addr;
    logic [AW-1:0]    copy_addr;
    logic [4:0]       need;
    logic             nb_ok;
    logic [AW-1:0]    nb_addr;
    logic [LBL_W:0]   v_sum;
    logic [LBL_W-1:0] v_lbl;
    logic [LBL_W:0]   diff_sum;
    logic             out_free;
    logic             last_cell;

    gwrc_ram #(.WIDTH(3), .DEPTH(GRID_CELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gwrc_ram #(.WIDTH(LBL_W), .DEPTH(GRID_CELLS)) u_lbl_ram (
        .clk   (clk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (lbl_raddr),
        .rdata (lbl_rdata)
    );

    assign in_grid   = int'(req.cell_index) < GRID_CELLS;
    assign req_addr  = AW'(req.cell_index);
    assign copy_addr = cnt_reg[AW-1:0] - AW'(1);
    assign need      = {1'b0, key_reg} + 5'd1;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign last_cell = pos_reg == AW'(GRID_CELLS - 1);
    assign req_ready = state_reg == ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        nb_ok   = 1'b0;
        nb_addr = pos_reg;
        case (nb_reg)
            3'd0:
            begin
                nb_ok   = z_reg != '0;
                nb_addr = pos_reg - AW'(LAYER_CELLS);
            end
            3'd1:
            begin
                nb_ok   = z_reg != CW'(GRID_SIDE - 1);
                nb_addr = pos_reg + AW'(LAYER_CELLS);
            end
            3'd2:
            begin
                nb_ok   = y_reg != '0;
                nb_addr = pos_reg - AW'(GRID_SIDE);
            end
            3'd3:
            begin
                nb_ok   = y_reg != CW'(GRID_SIDE - 1);
                nb_addr = pos_reg + AW'(GRID_SIDE);
            end
            3'd4:
            begin
                nb_ok   = x_reg != '0;
                nb_addr = pos_reg - AW'(1);
            end
            3'd5:
            begin
                nb_ok   = x_reg != CW'(GRID_SIDE - 1);
                nb_addr = pos_reg + AW'(1);
            end
            default:
            begin
                nb_ok   = 1'b0;
                nb_addr = pos_reg;
            end
        endcase
    end

    assign v_sum    = {1'b0, own_reg} + {1'b0, (nb_reg < 3'd2) ? COST_LAYER : COST_FLAT};
    assign v_lbl    = v_sum[LBL_W] ? LBL_MAX : v_sum[LBL_W-1:0];
    assign diff_sum = {1'b0, last_reg} + {{(LBL_W - 3){1'b0}}, key_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cand_next      = cand_reg;
        pos_next       = pos_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        nb_next        = nb_reg;
        own_next       = own_reg;
        last_next      = last_reg;
        found_next     = found_reg;
        changed_next   = changed_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        cell_we    = 1'b0;
        cell_waddr = req_addr;
        cell_wdata = req.cell_kind;
        cell_raddr = req_addr;
        lbl_we     = 1'b0;
        lbl_waddr  = nb_addr;
        lbl_wdata  = v_lbl;
        lbl_raddr  = pos_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = cnt_reg[AW-1:0];
                cell_wdata = KIND_EMPTY;
                cnt_next   = cnt_reg + (AW+1)'(1);
                if (cnt_reg == (AW+1)'(GRID_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.req_type == REQ_WRITE)
                    begin
                        cell_we = in_grid;
                    end
                    else
                    begin
                        cand_next  = req_addr;
                        found_next = '0;
                        state_next = in_grid ? ST_CHK : ST_FIN;
                    end
                end
            end
            ST_CHK:
            begin
                cnt_next   = '0;
                state_next = (cell_rdata == KIND_EMPTY) ? ST_COPY : ST_FIN;
            end
            ST_COPY:
            begin
                cell_raddr = cnt_reg[AW-1:0];
                lbl_waddr  = copy_addr;
                lbl_we     = cnt_reg != '0;
                if (copy_addr == cand_reg)
                begin
                    lbl_wdata = {{(LBL_W - 3){1'b0}}, KIND_WALL};
                end
                else if (cell_rdata == KIND_START)
                begin
                    lbl_wdata = LBL_BASE;
                end
                else
                begin
                    lbl_wdata = {{(LBL_W - 3){1'b0}}, cell_rdata};
                end
                cnt_next = cnt_reg + (AW+1)'(1);
                if (cnt_reg == (AW+1)'(GRID_CELLS))
                begin
                    last_next    = '0;
                    pos_next     = '0;
                    x_next       = '0;
                    y_next       = '0;
                    z_next       = '0;
                    changed_next = 1'b0;
                    state_next   = ST_SRD;
                end
            end
            ST_SRD:
            begin
                lbl_raddr  = pos_reg;
                state_next = ST_SOWN;
            end
            ST_SOWN:
            begin
                own_next   = lbl_rdata;
                nb_next    = '0;
                state_next = (lbl_rdata < LBL_BASE) ? ST_ADV : ST_NISS;
            end
            ST_NISS:
            begin
                lbl_raddr = nb_addr;
                if (nb_reg > 3'd5)
                begin
                    state_next = ST_ADV;
                end
                else if (nb_ok)
                begin
                    state_next = ST_NUSE;
                end
                else
                begin
                    nb_next = nb_reg + 3'd1;
                end
            end
            ST_NUSE:
            begin
                if (lbl_rdata != {{(LBL_W - 3){1'b0}}, KIND_WALL} && lbl_rdata < LBL_BASE)
                begin
                    lbl_we       = 1'b1;
                    changed_next = 1'b1;
                    if (lbl_rdata == {{(LBL_W - 3){1'b0}}, KIND_EXIT}
                        || lbl_rdata == {{(LBL_W - 3){1'b0}}, KIND_KEY})
                    begin
                        last_next = v_lbl - LBL_BASE;
                        if (found_reg != 5'd31)
                        begin
                            found_next = found_reg + 5'd1;
                        end
                    end
                end
                nb_next    = nb_reg + 3'd1;
                state_next = ST_NISS;
            end
            ST_ADV:
            begin
                pos_next = pos_reg + AW'(1);
                if (x_reg == CW'(GRID_SIDE - 1))
                begin
                    x_next = '0;
                    if (y_reg == CW'(GRID_SIDE - 1))
                    begin
                        y_next = '0;
                        z_next = z_reg + CW'(1);
                    end
                    else
                    begin
                        y_next = y_reg + CW'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + CW'(1);
                end
                state_next = ST_SRD;
                if (last_cell)
                begin
                    pos_next     = '0;
                    x_next       = '0;
                    y_next       = '0;
                    z_next       = '0;
                    changed_next = 1'b0;
                    if (!changed_reg || found_reg >= need)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (found_reg == need)
                    begin
                        rsp_next.placement_ok = 1'b1;
                        rsp_next.difficulty   = diff_sum[LBL_W] ? LBL_MAX
                                                                : diff_sum[LBL_W-1:0];
                    end
                    else
                    begin
                        rsp_next.placement_ok = 1'b0;
                        rsp_next.difficulty   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            found_reg     <= '0;
            changed_reg   <= 1'b0;
            last_reg      <= '0;
            key_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            changed_reg   <= changed_next;
            last_reg      <= last_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                key_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        pos_reg  <= pos_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        nb_reg   <= nb_next;
        own_reg  <= own_next;
        rsp_reg  <= rsp_next;
    end

endmodule
`default_nettype wire

[tb/grid_wavefront_reachability_check_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid wavefront reachability check: self-checking testbench
// Writes cell kinds and key counts, runs candidate-wall tests and compares
// every response beat with a local flood predictor, under random request
// gaps, random response stalls and one long response hold-off.
// ----------------------------------------------------------------------------
module grid_wavefront_reachability_check_test;
    import gwrc_pkg::*;

    localparam int CELLS = 512;
    localparam int SIDE = 8;
    localparam int LAYER = 64;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    logic cfg_we;
    logic [3:0] cfg_wdata;

    logic [2:0] grid_kind [CELLS];
    int flood_lbl [CELLS];
    int flood_found;
    int flood_last;
    bit flood_changed;
    logic [3:0] keys_needed;
    rsp_t verdict_queue [$];
    int mismatch_count;
    int unexpected_count;
    int burst_left;
    int hold_request;
    int hold_seen;
    int hold_count;
    int ready_mode;
    int ready_mode_left;
    int target_cells [$];

    grid_wavefront_reachability_check dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic void relax_cell(int q, int v);
        if (flood_lbl[q] != KIND_WALL && flood_lbl[q] < LBL_BASE)
        begin
            if (flood_lbl[q] == KIND_EXIT || flood_lbl[q] == KIND_KEY)
            begin
                flood_found++;
                flood_last = v - LBL_BASE;
            end
            flood_lbl[q] = v;
            flood_changed = 1;
        end
    endfunction

    function automatic int sat_label(int v);
        return (v > LBL_MAX) ? LBL_MAX : v;
    endfunction

    function automatic rsp_t flood_verdict(int cand);
        rsp_t r;
        int need;
        int p;
        int v;
        r = '0;
        if (grid_kind[cand] != KIND_EMPTY)
            return r;
        for (int i = 0; i < CELLS; i++)
            flood_lbl[i] = (grid_kind[i] == KIND_START) ? LBL_BASE : grid_kind[i];
        flood_lbl[cand] = KIND_WALL;
        need = keys_needed + 1;
        flood_found = 0;
        flood_last = 0;
        flood_changed = 1;
        while (flood_changed && flood_found < need)
        begin
            flood_changed = 0;
            for (int z = 0; z < SIDE; z++)
                for (int y = 0; y < SIDE; y++)
                    for (int x = 0; x < SIDE; x++)
                    begin
                        p = z * LAYER + y * SIDE + x;
                        if (flood_lbl[p] >= LBL_BASE)
                        begin
                            v = sat_label(flood_lbl[p] + COST_LAYER);
                            if (z > 0) relax_cell(p - LAYER, v);
                            if (z < SIDE - 1) relax_cell(p + LAYER, v);
                            v = sat_label(flood_lbl[p] + COST_FLAT);
                            if (y > 0) relax_cell(p - SIDE, v);
                            if (y < SIDE - 1) relax_cell(p + SIDE, v);
                            if (x > 0) relax_cell(p - 1, v);
                            if (x < SIDE - 1) relax_cell(p + 1, v);
                        end
                    end
        end
        if (flood_found == need)
        begin
            r.placement_ok = 1'b1;
            r.difficulty = 12'(sat_label(flood_last + keys_needed));
        end
        return r;
    endfunction

    task automatic send_beat(logic kind_of_req, int idx, logic [2:0] kind);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        if (kind_of_req == REQ_WRITE)
            grid_kind[idx] = kind;
        else
            verdict_queue.push_back(flood_verdict(idx));
        req_valid <= 1'b1;
        req <= '{req_type: kind_of_req, cell_index: 9'(idx), cell_kind: kind};
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain;
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (verdict_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_keys(logic [3:0] k);
        drain();
        keys_needed = k;
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic place_target(logic [2:0] kind);
        int c;
        c = $urandom_range(0, CELLS - 1);
        target_cells.push_back(c);
        send_beat(REQ_WRITE, c, kind);
    endtask

    task automatic clear_targets;
        while (target_cells.size() != 0)
            send_beat(REQ_WRITE, target_cells.pop_front(), KIND_EMPTY);
    endtask

    task automatic test_directed;
        set_keys(4'd0);
        send_beat(REQ_TEST, 5, 3'd0);
        send_beat(REQ_WRITE, 0, KIND_START);
        send_beat(REQ_WRITE, 511, KIND_EXIT);
        send_beat(REQ_TEST, 1, 3'd7);
        send_beat(REQ_TEST, 0, 3'd0);
        send_beat(REQ_TEST, 511, 3'd0);
        send_beat(REQ_WRITE, 64, KIND_WALL);
        send_beat(REQ_WRITE, 65, 3'd5);
        send_beat(REQ_WRITE, 66, 3'd6);
        send_beat(REQ_WRITE, 67, 3'd7);
        send_beat(REQ_TEST, 65, 3'd0);
        send_beat(REQ_TEST, 8, 3'd0);
        send_beat(REQ_WRITE, 2, KIND_KEY);
        send_beat(REQ_TEST, 100, 3'd0);
        set_keys(4'd1);
        send_beat(REQ_TEST, 100, 3'd0);
        send_beat(REQ_WRITE, 511, KIND_EMPTY);
        send_beat(REQ_TEST, 300, 3'd0);
        send_beat(REQ_WRITE, 1, KIND_WALL);
        send_beat(REQ_WRITE, 8, KIND_WALL);
        send_beat(REQ_TEST, 64, 3'd0);
        send_beat(REQ_TEST, 256, 3'd0);
    endtask

    task automatic test_max_keys;
        set_keys(4'd15);
        for (int i = 0; i < 15; i++)
            send_beat(REQ_WRITE, 200 + i * 19, KIND_KEY);
        send_beat(REQ_WRITE, 500, KIND_EXIT);
        send_beat(REQ_TEST, 400, 3'd0);
        send_beat(REQ_WRITE, 2, KIND_EMPTY);
        send_beat(REQ_TEST, 401, 3'd0);
        for (int i = 0; i < 15; i++)
            send_beat(REQ_WRITE, 200 + i * 19, KIND_EMPTY);
        send_beat(REQ_WRITE, 500, KIND_EMPTY);
        send_beat(REQ_WRITE, 0, KIND_EMPTY);
    endtask

    task automatic test_backpressure;
        set_keys(4'd0);
        hold_request++;
        for (int i = 0; i < 6; i++)
        begin
            send_beat(REQ_TEST, 1, 3'd0);
            send_beat(REQ_WRITE, 128 + i, KIND_WALL);
        end
    endtask

    task automatic test_random;
        int k;
        int c;
        for (int phase = 0; phase < 2; phase++)
        begin
            k = (phase == 1) ? 15 : $urandom_range(0, 3);
            set_keys(4'(k));
            clear_targets();
            place_target(KIND_START);
            if ($urandom_range(0, 2) == 0)
                place_target(KIND_START);
            place_target(KIND_EXIT);
            for (int i = 0; i < k; i++)
                place_target(KIND_KEY);
            if ($urandom_range(0, 3) == 0)
                place_target(KIND_KEY);
            for (int i = 0; i < 4; i++)
                send_beat(REQ_WRITE, $urandom_range(0, CELLS - 1),
                          ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                                      : KIND_WALL);
            for (int i = 0; i < 5; i++)
            begin
                c = $urandom_range(0, CELLS - 1);
                if ($urandom_range(0, 4) == 0 && target_cells.size() != 0)
                    c = target_cells[0];
                send_beat(REQ_TEST, c, 3'($urandom));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 0;
            hold_count <= 0;
        end
        else if (hold_seen != hold_request)
        begin
            hold_seen <= hold_request;
            hold_count <= 3000;
        end
        else if (hold_count > 0)
            hold_count <= hold_count - 1;
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (verdict_queue.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("Unexpected response beat: ok=%0d difficulty=%0d",
                             rsp.placement_ok, rsp.difficulty);
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (rsp.placement_ok !== want.placement_ok
                    || rsp.difficulty !== want.difficulty)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("Mismatch: expected ok=%0d difficulty=%0d, got ok=%0d difficulty=%0d",
                                 want.placement_ok, want.difficulty,
                                 rsp.placement_ok, rsp.difficulty);
                end
            end
        end
        if (ready_mode_left == 0)
        begin
            ready_mode_left = $urandom_range(16, 96);
            ready_mode = $urandom_range(0, 2);
        end
        ready_mode_left--;
        if (hold_count > 0 || hold_seen != hold_request)
            rsp_ready <= 1'b0;
        else if (ready_mode == 0)
            rsp_ready <= 1'b1;
        else if (ready_mode == 1)
            rsp_ready <= $urandom_range(0, 1);
        else
            rsp_ready <= ($urandom_range(0, 7) == 0);
    end

    initial
    begin
        #(12 * 40_000_000);
        $display("** grid_wavefront_reachability_check: FAILED **");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        keys_needed = '0;
        mismatch_count = 0;
        unexpected_count = 0;
        burst_left = 0;
        hold_request = 0;
        ready_mode = 0;
        ready_mode_left = 0;
        for (int i = 0; i < CELLS; i++)
            grid_kind[i] = KIND_EMPTY;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_max_keys();
        test_backpressure();
        test_random();
        drain();
        if (mismatch_count == 0 && unexpected_count == 0 && verdict_queue.size() == 0)
            $display("** grid_wavefront_reachability_check: PASSED **");
        else
            $display("** grid_wavefront_reachability_check: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/gwrc_pkg.sv
rtl/gwrc_ram.sv
rtl/grid_wavefront_reachability_check.sv
tb/grid_wavefront_reachability_check_test.sv
